FILE: design/awc_pkg.sv
package awc_pkg;

  // fixed field widths
  localparam int SYMBOL_W = 8;
  localparam int TOTAL_W  = 32;

  // operation codes of an input item
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_WR,
    ST_OLD_RD,
    ST_LEAVE_WR,
    ST_ENTER_RD,
    ST_ENTER_WR,
    ST_DONE
  } state_t;

endpackage

FILE: design/anagram_window_counter.sv
// Sliding-window anagram counter. Stream a pattern as operation=0 items (first=1 on the
// first byte starts a new search and clears everything), then text as operation=1 items;
// every item gives exactly one result transfer carrying window_full, anagram_here, the
// saturating match_total and error. Per-symbol counts live in a single-port table of
// ALPHABET_SIZE entries with one valid flip-flop per entry, so a new search clears at once
// with no sweep. The block takes one item at a time and all work goes through that
// single count-table port: an error item goes straight to the result, a pattern item or a
// text item while the window fills takes one read-modify-write, and a text item on a full
// window takes a ring read, then a read-modify-write for the leaving symbol and another for
// the entering symbol. The finished result sits in an output register; the next item is
// taken once that register has a free slot.
module anagram_window_counter #(
  parameter int MAX_PATTERN   = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [awc_pkg::SYMBOL_W-1:0] in_symbol,
  input  logic                         in_first,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_window_full,
  output logic                         out_anagram_here,
  output logic [awc_pkg::TOTAL_W-1:0]  out_match_total,
  output logic                         out_error
);
  import awc_pkg::*;

  localparam int SYM_W   = $clog2(ALPHABET_SIZE);
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BAL_W   = LEN_W + 1;       // balance spans -MAX_PATTERN..MAX_PATTERN
  localparam int ENT_W   = BAL_W + 1;       // {in_pattern, balance}
  localparam int SYM_VALS = 1 << SYMBOL_W;

  // symbol reduction table, constant
  logic [SYM_W-1:0] sym_mod [SYM_VALS];
  for (genvar g = 0; g < SYM_VALS; g++) begin : g_sym_mod
    assign sym_mod[g] = SYM_W'(g % ALPHABET_SIZE);
  end

  // control state
  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   plen_r, plen_nxt;
  logic [LEN_W-1:0]   fill_r, fill_nxt;
  logic [LEN_W-1:0]   um_r, um_nxt;
  logic [RING_AW-1:0] pos_r, pos_nxt;
  logic [TOTAL_W-1:0] match_r, match_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ALPHABET_SIZE-1:0] vld_r;

  // payload
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               res_full_r, res_full_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_err_r, out_err_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  // count table and text ring
  logic [ENT_W-1:0]   bal_mem [ALPHABET_SIZE];
  logic [ENT_W-1:0]   bal_q;
  logic               vld_q;
  logic [SYM_W-1:0]   ring_mem [MAX_PATTERN];
  logic [SYM_W-1:0]   ring_q;

  logic               bal_re, bal_we;
  logic [SYM_W-1:0]   bal_ra, bal_wa;
  logic [ENT_W-1:0]   bal_wd;
  logic               ring_we;

  logic               in_acc;
  logic               new_search;
  logic               pat_err, txt_err, win_at_len;
  logic [SYM_W-1:0]   sym_in;
  logic [RING_AW-1:0] old_addr;
  logic [LEN_W:0]     old_wide;
  logic               ent_inpat;
  logic [BAL_W-1:0]   ent_bal, bal_inc, bal_dec;
  logic               out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid & in_ready;
  assign sym_in     = sym_mod[in_symbol];
  assign new_search = in_acc && (in_operation == OP_PATTERN) && in_first;
  // a first-flagged pattern byte sees cleared state, so it is never rejected
  assign pat_err    = !in_first && ((plen_r >= LEN_W'(MAX_PATTERN)) || (fill_r != '0));
  assign txt_err    = (plen_r == '0);
  assign win_at_len = (fill_r >= plen_r);
  assign out_free   = !out_valid_r || out_ready;

  // oldest ring slot: (pos - plen) mod MAX_PATTERN
  always_comb begin
    if ((LEN_W + 1)'(pos_r) >= (LEN_W + 1)'(plen_r)) begin
      old_wide = (LEN_W + 1)'(pos_r) - (LEN_W + 1)'(plen_r);
    end else begin
      old_wide = (LEN_W + 1)'(pos_r) + (LEN_W + 1)'(MAX_PATTERN) - (LEN_W + 1)'(plen_r);
    end
    old_addr = old_wide[RING_AW-1:0];
  end

  // table entry as read; an entry never written since the last clear reads as zero
  assign ent_inpat = vld_q & bal_q[ENT_W-1];
  assign ent_bal   = vld_q ? bal_q[BAL_W-1:0] : '0;
  assign bal_inc   = ent_bal + BAL_W'(1);
  assign bal_dec   = ent_bal - BAL_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_PATTERN) begin
            state_nxt = pat_err ? ST_DONE : ST_PAT_WR;
          end else if (txt_err) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = win_at_len ? ST_OLD_RD : ST_ENTER_WR;
          end
        end
      end
      ST_PAT_WR:   state_nxt = ST_DONE;
      ST_OLD_RD:   state_nxt = ST_LEAVE_WR;
      ST_LEAVE_WR: state_nxt = ST_ENTER_RD;
      ST_ENTER_RD: state_nxt = ST_ENTER_WR;
      ST_ENTER_WR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // count table port and ring write control
  always_comb begin
    bal_re  = 1'b0;
    bal_ra  = sym_in;
    bal_we  = 1'b0;
    bal_wa  = sym_r;
    bal_wd  = {1'b1, bal_inc};
    ring_we = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // pattern byte, or text byte while the window is still filling
        bal_re = in_acc &&
                 (((in_operation == OP_PATTERN) && !pat_err) ||
                  ((in_operation == OP_TEXT) && !txt_err && !win_at_len));
      end
      ST_PAT_WR: begin
        bal_we = 1'b1;
      end
      ST_OLD_RD: begin
        // leaving symbol comes out of the ring
        bal_re = 1'b1;
        bal_ra = ring_q;
      end
      ST_LEAVE_WR: begin
        bal_we = ent_inpat;
        bal_wa = ring_q;
      end
      ST_ENTER_RD: begin
        bal_re = 1'b1;
        bal_ra = sym_r;
      end
      ST_ENTER_WR: begin
        bal_we  = ent_inpat;
        bal_wd  = {1'b1, bal_dec};
        ring_we = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // counters and result
  always_comb begin
    plen_nxt      = plen_r;
    fill_nxt      = fill_r;
    um_nxt        = um_r;
    pos_nxt       = pos_r;
    match_nxt     = match_r;
    sym_nxt       = sym_r;
    res_full_nxt  = res_full_r;
    res_hit_nxt   = res_hit_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_full_nxt  = out_full_r;
    out_hit_nxt   = out_hit_r;
    out_err_nxt   = out_err_r;
    out_total_nxt = out_total_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sym_nxt      = sym_in;
          res_full_nxt = 1'b0;
          res_hit_nxt  = 1'b0;
          if (new_search) begin
            plen_nxt  = '0;
            fill_nxt  = '0;
            um_nxt    = '0;
            pos_nxt   = '0;
            match_nxt = '0;
          end
          if (in_operation == OP_PATTERN) begin
            res_err_nxt = pat_err;
          end else begin
            res_err_nxt = txt_err;
            if (!txt_err && !win_at_len) begin
              fill_nxt = fill_r + LEN_W'(1);
            end
          end
        end
      end
      ST_PAT_WR: begin
        plen_nxt = plen_r + LEN_W'(1);
        if (ent_bal == '0) begin
          um_nxt = um_r + LEN_W'(1);
        end
      end
      ST_LEAVE_WR: begin
        if (ent_inpat && (bal_inc == BAL_W'(1))) begin
          um_nxt = um_r + LEN_W'(1);
        end
      end
      ST_ENTER_WR: begin
        if (ent_inpat && (bal_dec == '0) && (um_r != '0)) begin
          um_nxt = um_r - LEN_W'(1);
        end
        pos_nxt      = (pos_r == RING_AW'(MAX_PATTERN - 1)) ? '0 : pos_r + RING_AW'(1);
        res_full_nxt = (fill_r == plen_r);
        res_hit_nxt  = (fill_r == plen_r) && (um_nxt == '0);
        if (res_hit_nxt && (match_r != '1)) begin
          match_nxt = match_r + TOTAL_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = res_full_r;
          out_hit_nxt   = res_hit_r;
          out_err_nxt   = res_err_r;
          out_total_nxt = match_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      fill_r      <= '0;
      um_r        <= '0;
      pos_r       <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      fill_r      <= fill_nxt;
      um_r        <= um_nxt;
      pos_r       <= pos_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-entry valid bits, cleared at once on reset or a new search
  always_ff @(posedge clk) begin
    if (!rst_n || new_search) begin
      vld_r <= '0;
    end else if (bal_we) begin
      vld_r[bal_wa] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    res_full_r  <= res_full_nxt;
    res_hit_r   <= res_hit_nxt;
    res_err_r   <= res_err_nxt;
    out_full_r  <= out_full_nxt;
    out_hit_r   <= out_hit_nxt;
    out_err_r   <= out_err_nxt;
    out_total_r <= out_total_nxt;
  end

  // count table: one port, registered read
  always_ff @(posedge clk) begin
    if (bal_we) begin
      bal_mem[bal_wa] <= bal_wd;
    end
    if (bal_re) begin
      bal_q <= bal_mem[bal_ra];
      vld_q <= new_search ? 1'b0 : vld_r[bal_ra];
    end
  end

  // text ring: oldest slot read while idle, new symbol written at the end of a text item
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos_r] <= sym_r;
    end
    if (state_r == ST_IDLE) begin
      ring_q <= ring_mem[old_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_full  = out_full_r;
  assign out_anagram_here = out_hit_r;
  assign out_match_total  = out_total_r;
  assign out_error        = out_err_r;

endmodule

FILE: design/awc_checker.sv
module awc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_window_full,
  input logic                         out_anagram_here,
  input logic [awc_pkg::TOTAL_W-1:0]  out_match_total,
  input logic                         out_error
);
  import awc_pkg::*;

  logic [1:0] pend_r;

  // items taken in whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'((in_valid && in_ready) ? 1 : 0)
                       - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result without an outstanding item");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (!out_window_full && !out_anagram_here))
    else $error("rejected item reports a window");

  a_hit_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_anagram_here) |-> out_window_full)
    else $error("anagram reported on a partial window");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_match_total) && $stable(out_error)))
    else $error("stalled result changed");

endmodule

bind anagram_window_counter awc_checker u_awc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_window_full  (out_window_full),
  .out_anagram_here (out_anagram_here),
  .out_match_total  (out_match_total),
  .out_error        (out_error)
);
